// ===== rtl/htc_pkg.sv =====
`default_nettype none
package htc_pkg;
    // configuration register indexes
    localparam logic [2:0] CFG_TEMP_CAL_ONE   = 3'd0;
    localparam logic [2:0] CFG_TEMP_CAL_TWO   = 3'd1;
    localparam logic [2:0] CFG_TEMP_CAL_THREE = 3'd2;
    localparam logic [2:0] CFG_HUM_CAL_TWO    = 3'd3;
    localparam logic [2:0] CFG_HUM_CAL_FOUR   = 3'd4;
    localparam logic [2:0] CFG_HUM_CAL_FIVE   = 3'd5;
    localparam logic [2:0] CFG_HUM_CAL_SMALL  = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 40;

    // pipeline depth, input register to output register
    localparam int NSTG = 13;

    localparam logic [16:0] HUM_FULL = 17'd102400;
endpackage
`default_nettype wire

// ===== rtl/humidity_temperature_compensation.sv =====
`default_nettype none
// Channel   Direction  Handshake           Payload
// s_*       in         s_tvalid/s_tready   [19:0] adc_temp, [35:20] adc_hum
// m_*       out        m_tvalid/m_tready   [15:0] temp_centi, [32:16] hum_frac
// i_cfg_*   in         i_cfg_we            i_cfg_idx register, i_cfg_data value
//
// Thirteen register stages; one item per cycle while m_tready does not stall.
// The depth is set by the multiplier chain of the humidity path. Reset
// clears the valid bits and the calibration words.
// A stall on m_tready freezes every stage together; nothing is dropped.
module humidity_temperature_compensation (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire [htc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [htc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // [19:0] adc_temp, [35:20] adc_hum, [39:36] zero
    input  wire [htc_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // [15:0] temp_centi, [32:16] hum_frac, [39:33] zero
    output logic [htc_pkg::M_DATA_W-1:0]    m_tdata
);
    import htc_pkg::*;

    // calibration words
    logic [15:0] r_t1, r_t2, r_t3, r_h2;
    logic [11:0] r_h4, r_h5;
    logic [23:0] r_hs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0; r_t2 <= '0; r_t3 <= '0; r_h2 <= '0;
            r_h4 <= '0; r_h5 <= '0; r_hs <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TEMP_CAL_ONE:   r_t1 <= i_cfg_data[15:0];
                CFG_TEMP_CAL_TWO:   r_t2 <= i_cfg_data[15:0];
                CFG_TEMP_CAL_THREE: r_t3 <= i_cfg_data[15:0];
                CFG_HUM_CAL_TWO:    r_h2 <= i_cfg_data[15:0];
                CFG_HUM_CAL_FOUR:   r_h4 <= i_cfg_data[11:0];
                CFG_HUM_CAL_FIVE:   r_h5 <= i_cfg_data[11:0];
                CFG_HUM_CAL_SMALL:  r_hs <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [15:0] t2, t3, h2;
    logic signed [11:0] h4, h5;
    logic signed [8:0]  h1, h3;
    logic signed [7:0]  h6;
    assign t2 = $signed(r_t2);
    assign t3 = $signed(r_t3);
    assign h2 = $signed(r_h2);
    assign h4 = $signed(r_h4);
    assign h5 = $signed(r_h5);
    assign h1 = $signed({1'b0, r_hs[7:0]});
    assign h3 = $signed({1'b0, r_hs[15:8]});
    assign h6 = $signed(r_hs[23:16]);

    // whole pipeline advances when the output slot is free or taken
    logic            en;
    logic [NSTG-1:0] r_vld;
    assign en       = !r_vld[NSTG-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], s_tvalid};
        end
    end

    // payload registers
    logic [15:0]        r_ah [0:5];
    logic signed [20:0] r_d;
    logic signed [36:0] r_dt2, r_dt2b;
    logic signed [41:0] r_dsq;
    logic signed [57:0] r_ddt3;
    logic signed [31:0] r_fq8;
    logic signed [24:0] r_v;
    logic signed [15:0] r_cen [0:8];
    logic signed [36:0] r_h5v;
    logic signed [33:0] r_h3v;
    logic signed [32:0] r_h6v, r_h6vb;
    logic signed [33:0] r_a;
    logic signed [18:0] r_c;
    logic signed [49:0] r_ap;
    logic signed [51:0] r_hvc;
    logic signed [60:0] r_pd;
    logic signed [32:0] r_v1, r_v1b;
    logic signed [41:0] r_hv1;
    logic signed [57:0] r_v1e;
    logic [16:0]        r_hum;

    // combinational step values
    logic signed [57:0] n_s;
    logic signed [23:0] n_tf;
    logic signed [34:0] n_c5;
    logic signed [18:0] n_cs;
    logic signed [15:0] n_cen;
    logic signed [37:0] n_asum;
    logic signed [33:0] n_p;
    logic signed [26:0] n_dd;
    logic signed [50:0] n_v1f;
    logic signed [32:0] n_v1;
    logic signed [24:0] n_e;
    logic signed [47:0] n_v2;
    logic [16:0]        n_hum;

    always_comb begin
        n_s  = $signed({r_dt2b[36], r_dt2b, 20'b0}) + r_ddt3;
        n_tf = 24'(($signed(r_fq8) + (r_fq8[31] ? 32'sd255 : 32'sd0)) >>> 8);
        n_c5 = $signed({{3{r_fq8[31]}}, r_fq8}) * 35'sd5 + 35'sd32768;
        n_cs = n_c5[34:16];
        if (n_cs > 19'sd32767)       n_cen = 16'sh7fff;
        else if (n_cs < -19'sd32768) n_cen = 16'sh8000;
        else                         n_cen = n_cs[15:0];
        n_asum = $signed({8'b0, r_ah[5], 14'b0})
               - $signed({{6{h4[11]}}, h4, 20'b0})
               - $signed({r_h5v[36], r_h5v});
        n_p  = r_ap[49:16];
        n_dd = 27'sd1024 + $signed({r_hvc[51], r_hvc[51:26]});
        n_v1f = r_pd[60:10];
        if (n_v1f > 51'sd2147483648)       n_v1 = 33'sh0_8000_0000;
        else if (n_v1f < -51'sd2147483648) n_v1 = 33'sh1_8000_0000;
        else                               n_v1 = n_v1f[32:0];
        n_e  = 25'sd1024 - $signed({{2{r_hv1[41]}}, r_hv1[41:19]});
        n_v2 = r_v1e[57:10];
        if (n_v2 < 48'sd0)                         n_hum = '0;
        else if (n_v2 > $signed({31'b0, HUM_FULL})) n_hum = HUM_FULL;
        else                                       n_hum = n_v2[16:0];
    end

    // advance all stages together
    always_ff @(posedge i_clk) begin
        if (en) begin
            // stage 1: offset removal
            r_d     <= $signed({1'b0, s_tdata[19:0]}) - $signed({1'b0, r_t1, 4'b0});
            r_ah[0] <= s_tdata[35:20];
            for (int k = 1; k < 6; k++) r_ah[k] <= r_ah[k-1];
            // stage 2: linear and square products
            r_dt2  <= r_d * t2;
            r_dsq  <= r_d * r_d;
            // stage 3: quadratic term
            r_ddt3 <= r_dsq * t3;
            r_dt2b <= r_dt2;
            // stage 4: fine temperature, 8 fraction bits
            r_fq8  <= n_s[57:26];
            // stage 5: integer fine temperature offset, centidegrees
            r_v      <= $signed({n_tf[23], n_tf}) - 25'sd76800;
            r_cen[0] <= n_cen;
            for (int k = 1; k < 9; k++) r_cen[k] <= r_cen[k-1];
            // stage 6: temperature products for humidity
            r_h5v  <= h5 * r_v;
            r_h3v  <= h3 * r_v;
            r_h6v  <= h6 * r_v;
            // stage 7: offset term and first correction
            r_a    <= n_asum[37:4];
            r_c    <= 19'sd1024 + $signed({r_h3v[33], r_h3v[33:16]});
            r_h6vb <= r_h6v;
            // stage 8: gain and second correction products
            r_ap   <= r_a * h2;
            r_hvc  <= r_h6vb * r_c;
            // stage 9: combined humidity product
            r_pd   <= n_p * n_dd;
            // stage 10: saturate intermediate
            r_v1   <= n_v1;
            // stage 11: self-heating product
            r_hv1  <= h1 * r_v1;
            r_v1b  <= r_v1;
            // stage 12: final product
            r_v1e  <= r_v1b * n_e;
            // stage 13: clamp and output
            r_hum  <= n_hum;
        end
    end

    assign m_tdata = {7'b0, r_hum, r_cen[8]};

    // stall freezes the valid line
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("valid bits moved during stall");
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("ready does not follow output slot");
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("pipeline not empty after reset");
    a_take_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && s_tvalid) |=> r_vld[0])
        else $error("accepted item not entered");
endmodule
`default_nettype wire
